// ===== rtl/ussc_pkg.sv =====
`default_nettype none
package ussc_pkg;

  localparam int CntW  = 6;
  localparam int ProdW = CntW + 4;
  localparam int FlagW = 10;
  localparam int WFlagW = 8;

  localparam int FCtl   = 0;
  localparam int FUuid  = 1;
  localparam int FUlid  = 2;
  localparam int FDate  = 3;
  localparam int FB64   = 4;
  localparam int FUp    = 5;
  localparam int FLo    = 6;
  localparam int FDig   = 7;
  localparam int FAlnum = 8;
  localparam int FAlpha = 9;

  localparam logic [FlagW-1:0] CompFlagsReset = FlagW'(10'h11e);
  localparam logic [WFlagW-1:0] WholeFlagsReset = WFlagW'(8'h1e);

  localparam int UuidLen  = 36;
  localparam int UlidLen  = 26;
  localparam int DateLen  = 10;
  localparam int DateDash1 = 4;
  localparam int DateDash2 = 7;
  localparam int UuidGroups [5] = '{8, 4, 4, 4, 12};

  localparam logic [7:0] ChCtlTop = 8'h20;
  localparam logic [7:0] ChDel    = 8'h7f;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChDash   = 8'h2d;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChEq     = 8'h3d;
  localparam logic [7:0] ChUnder  = 8'h5f;
  localparam logic [7:0] ChCase   = 8'h20;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [2:0] RegMaxLiteralLen   = 3'd0;
  localparam logic [2:0] RegMinHexLen       = 3'd1;
  localparam logic [2:0] RegMinB64Len       = 3'd2;
  localparam logic [2:0] RegMinDenseLen     = 3'd3;
  localparam logic [2:0] RegDenseDigitTenth = 3'd4;
  localparam logic [2:0] RegMaxExtLen       = 3'd5;

  typedef enum logic [1:0] {
    VerdictLiteral = 2'd0,
    VerdictId      = 2'd1,
    VerdictStem    = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [5:0] max_literal_len;
    logic [5:0] min_hex_len;
    logic [5:0] min_b64_len;
    logic [5:0] min_dense_len;
    logic [3:0] dense_digit_tenths;
    logic [5:0] max_ext_len;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0]  len;
    logic [CntW-1:0]  dig;
    logic [CntW-1:0]  hex;
    logic [FlagW-1:0] flags;
  } cnt_t;

  typedef struct packed {
    logic [CntW-1:0]   whole_len;
    logic [CntW-1:0]   whole_dig;
    logic [CntW-1:0]   whole_hex;
    logic [WFlagW-1:0] whole_flags;
    logic [CntW-1:0]   comp_len;
    logic              comp_alnum;
    logic              comp_alpha;
    logic              prev_opaque;
    logic              dot_seen;
    logic              dot_first;
  } seg_rec_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == {CntW{1'b1}}) ? v : v + CntW'(1);
  endfunction

  function automatic logic is_uuid_dash(input logic [CntW-1:0] pos);
    int   edge_pos;
    logic hit;
    edge_pos = 0;
    hit = 1'b0;
    for (int g = 0; g < 4; g++) begin
      edge_pos = edge_pos + UuidGroups[g];
      if (int'(pos) == edge_pos) hit = 1'b1;
      edge_pos = edge_pos + 1;
    end
    return hit;
  endfunction

  function automatic cnt_t absorb(input logic [7:0] c, input cnt_t s);
    cnt_t       r;
    logic       d;
    logic       up;
    logic       lo;
    logic       hx;
    logic       b64;
    logic [7:0] uc;
    r   = s;
    d   = (c >= 8'h30) && (c <= 8'h39);
    up  = (c >= 8'h41) && (c <= 8'h5a);
    lo  = (c >= 8'h61) && (c <= 8'h7a);
    hx  = d || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    uc  = lo ? c - ChCase : c;
    b64 = d || up || lo || (c == ChPlus) || (c == ChSlash) || (c == ChEq) ||
          (c == ChDash) || (c == ChUnder);
    if ((c < ChCtlTop) || (c == ChDel)) r.flags[FCtl] = 1'b1;
    if (d) r.dig = sat_inc(s.dig);
    if (hx) r.hex = sat_inc(s.hex);
    if (up) begin
      r.flags[FUp] = 1'b1;
      r.flags[FAlpha] = 1'b1;
    end
    if (lo) begin
      r.flags[FLo] = 1'b1;
      r.flags[FAlpha] = 1'b1;
    end
    if (d) r.flags[FDig] = 1'b1;
    if (!(d || up || lo)) r.flags[FAlnum] = 1'b0;
    if (int'(s.len) < UuidLen) begin
      if (is_uuid_dash(s.len) ? (c != ChDash) : !hx) r.flags[FUuid] = 1'b0;
    end
    if (!d && (!(up || lo) || uc == 8'h49 || uc == 8'h4c || uc == 8'h4f || uc == 8'h55)) begin
      r.flags[FUlid] = 1'b0;
    end
    if (int'(s.len) < DateLen) begin
      if ((int'(s.len) == DateDash1 || int'(s.len) == DateDash2) ? (c != ChDash) : !d) begin
        r.flags[FDate] = 1'b0;
      end
    end
    if (!b64) r.flags[FB64] = 1'b0;
    r.len = sat_inc(s.len);
    return r;
  endfunction

  function automatic logic opaque(input cnt_t s, input cfg_t cfg);
    logic [ProdW-1:0] dig10;
    logic [ProdW-1:0] len_t;
    logic             res;
    dig10 = ProdW'(s.dig) * ProdW'(10);
    len_t = ProdW'(s.len) * ProdW'(cfg.dense_digit_tenths);
    res = s.flags[FCtl] ||
          (s.dig == s.len) ||
          (int'(s.len) > int'(cfg.max_literal_len)) ||
          ((s.hex == s.len) && (int'(s.len) >= int'(cfg.min_hex_len))) ||
          (s.flags[FUuid] && int'(s.len) == UuidLen) ||
          (s.flags[FUlid] && int'(s.len) == UlidLen) ||
          (s.flags[FDate] && int'(s.len) == DateLen) ||
          (s.flags[FB64] && (int'(s.len) >= int'(cfg.min_b64_len)) &&
           s.flags[FUp] && s.flags[FLo] && s.flags[FDig]) ||
          ((int'(s.len) >= int'(cfg.min_dense_len)) && (dig10 > len_t));
    return (s.len != '0) && res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/url_segment_shape_classifier_unit.sv =====
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata seg_byte, tlast end_of_segment,
//                                                tuser no_byte
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata verdict, ext_len
// apb       in   psel, penable, pwrite, pready   six config registers at 4*i
//
// one input beat per cycle while the record queue is not full; the verdict of a segment passes
// from its closing beat through the two-entry record queue into the output register
// reset clears all counters, loads the flag reset patterns and loads the register defaults
// input stalls only when the record queue is full, output stalls hold the verdict
`default_nettype none
module url_segment_shape_classifier_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] seg_byte
  input  wire logic        s_axis_tlast,
  input  wire logic [0:0]  s_axis_tuser,   // [0] no_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [1:0] verdict, [7:2] ext_len
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  ussc_pkg::cfg_t      cfg_q;
  logic [2:0]          reg_idx;
  logic                cfg_wr;
  logic                q_full;
  logic                push;
  ussc_pkg::seg_rec_t  push_rec;
  logic                q_valid;
  logic                pop;
  ussc_pkg::seg_rec_t  head_rec;
  ussc_pkg::verdict_e  verdict;
  logic [5:0]          ext_len;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_literal_len    <= 6'd24;
      cfg_q.min_hex_len        <= 6'd8;
      cfg_q.min_b64_len        <= 6'd16;
      cfg_q.min_dense_len      <= 6'd6;
      cfg_q.dense_digit_tenths <= 4'd4;
      cfg_q.max_ext_len        <= 6'd8;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ussc_pkg::RegMaxLiteralLen:   cfg_q.max_literal_len    <= pwdata[5:0];
        ussc_pkg::RegMinHexLen:       cfg_q.min_hex_len        <= pwdata[5:0];
        ussc_pkg::RegMinB64Len:       cfg_q.min_b64_len        <= pwdata[5:0];
        ussc_pkg::RegMinDenseLen:     cfg_q.min_dense_len      <= pwdata[5:0];
        ussc_pkg::RegDenseDigitTenth: cfg_q.dense_digit_tenths <= pwdata[3:0];
        ussc_pkg::RegMaxExtLen:       cfg_q.max_ext_len        <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ussc_pkg::RegMaxLiteralLen:   prdata = 32'(cfg_q.max_literal_len);
      ussc_pkg::RegMinHexLen:       prdata = 32'(cfg_q.min_hex_len);
      ussc_pkg::RegMinB64Len:       prdata = 32'(cfg_q.min_b64_len);
      ussc_pkg::RegMinDenseLen:     prdata = 32'(cfg_q.min_dense_len);
      ussc_pkg::RegDenseDigitTenth: prdata = 32'(cfg_q.dense_digit_tenths);
      ussc_pkg::RegMaxExtLen:       prdata = 32'(cfg_q.max_ext_len);
      default:                      prdata = '0;
    endcase
  end

  ussc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .valid_i          (s_axis_tvalid),
    .ready_o          (s_axis_tready),
    .seg_byte_i       (s_axis_tdata),
    .end_of_segment_i (s_axis_tlast),
    .no_byte_i        (s_axis_tuser[0]),
    .q_full_i         (q_full),
    .push_o           (push),
    .rec_o            (push_rec)
  );

  ussc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rec_o   (head_rec)
  );

  ussc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .rec_i     (head_rec),
    .pop_o     (pop),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .verdict_o (verdict),
    .ext_len_o (ext_len)
  );

  assign m_axis_tdata = {ext_len, verdict};

endmodule
`default_nettype wire

// ===== rtl/ussc_front.sv =====
`default_nettype none
module ussc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ussc_pkg::cfg_t    cfg_i,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [7:0]        seg_byte_i,
  input  wire logic              end_of_segment_i,
  input  wire logic              no_byte_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output ussc_pkg::seg_rec_t     rec_o
);

  ussc_pkg::cnt_t                        comp_q, comp_d, comp_upd;
  logic [ussc_pkg::CntW-1:0]             whole_len_q, whole_len_d;
  logic [ussc_pkg::CntW-1:0]             whole_dig_q, whole_dig_d;
  logic [ussc_pkg::CntW-1:0]             whole_hex_q, whole_hex_d;
  logic [ussc_pkg::WFlagW-1:0]           whole_flags_q, whole_flags_d;
  ussc_pkg::cnt_t                        whole_cur, whole_upd;
  logic                                  prev_q, prev_d, prev_upd;
  logic [1:0]                            dot_q, dot_d, dot_upd;
  logic                                  fire;

  assign ready_o = !q_full_i;
  assign fire    = valid_i && ready_o;
  assign push_o  = fire && end_of_segment_i;

  assign whole_cur = '{len: whole_len_q, dig: whole_dig_q, hex: whole_hex_q,
                       flags: {2'b00, whole_flags_q}};

  always_comb begin
    comp_upd  = comp_q;
    whole_upd = whole_cur;
    prev_upd  = prev_q;
    dot_upd   = dot_q;
    if (!no_byte_i) begin
      if (seg_byte_i == ussc_pkg::ChDot) begin
        if (ussc_pkg::opaque(comp_q, cfg_i)) prev_upd = 1'b1;
        dot_upd  = {(whole_len_q == '0), 1'b1};
        comp_upd = '{len: '0, dig: '0, hex: '0, flags: ussc_pkg::CompFlagsReset};
      end else begin
        comp_upd = ussc_pkg::absorb(seg_byte_i, comp_q);
      end
      whole_upd = ussc_pkg::absorb(seg_byte_i, whole_cur);
    end
  end

  always_comb begin
    rec_o.whole_len   = whole_upd.len;
    rec_o.whole_dig   = whole_upd.dig;
    rec_o.whole_hex   = whole_upd.hex;
    rec_o.whole_flags = whole_upd.flags[ussc_pkg::WFlagW-1:0];
    rec_o.comp_len    = comp_upd.len;
    rec_o.comp_alnum  = comp_upd.flags[ussc_pkg::FAlnum];
    rec_o.comp_alpha  = comp_upd.flags[ussc_pkg::FAlpha];
    rec_o.prev_opaque = prev_upd;
    rec_o.dot_seen    = dot_upd[0];
    rec_o.dot_first   = dot_upd[1];
  end

  always_comb begin
    comp_d        = comp_q;
    whole_len_d   = whole_len_q;
    whole_dig_d   = whole_dig_q;
    whole_hex_d   = whole_hex_q;
    whole_flags_d = whole_flags_q;
    prev_d        = prev_q;
    dot_d         = dot_q;
    if (fire) begin
      if (end_of_segment_i) begin
        comp_d        = '{len: '0, dig: '0, hex: '0, flags: ussc_pkg::CompFlagsReset};
        whole_len_d   = '0;
        whole_dig_d   = '0;
        whole_hex_d   = '0;
        whole_flags_d = ussc_pkg::WholeFlagsReset;
        prev_d        = 1'b0;
        dot_d         = 2'b00;
      end else begin
        comp_d        = comp_upd;
        whole_len_d   = whole_upd.len;
        whole_dig_d   = whole_upd.dig;
        whole_hex_d   = whole_upd.hex;
        whole_flags_d = whole_upd.flags[ussc_pkg::WFlagW-1:0];
        prev_d        = prev_upd;
        dot_d         = dot_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q        <= '{len: '0, dig: '0, hex: '0, flags: ussc_pkg::CompFlagsReset};
      whole_len_q   <= '0;
      whole_dig_q   <= '0;
      whole_hex_q   <= '0;
      whole_flags_q <= ussc_pkg::WholeFlagsReset;
      prev_q        <= 1'b0;
      dot_q         <= 2'b00;
    end else begin
      comp_q        <= comp_d;
      whole_len_q   <= whole_len_d;
      whole_dig_q   <= whole_dig_d;
      whole_hex_q   <= whole_hex_d;
      whole_flags_q <= whole_flags_d;
      prev_q        <= prev_d;
      dot_q         <= dot_d;
    end
  end

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (whole_len_q == '0) && (comp_q.len == '0) && !prev_q && (dot_q == 2'b00))
    else $error("segment state not cleared after closing beat");

endmodule
`default_nettype wire

// ===== rtl/ussc_queue.sv =====
`default_nettype none
module ussc_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire ussc_pkg::seg_rec_t  rec_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output ussc_pkg::seg_rec_t       rec_o
);

  ussc_pkg::seg_rec_t                 mem_q [ussc_pkg::QDepth];
  logic [ussc_pkg::QPtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [ussc_pkg::QPtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [ussc_pkg::QCntW-1:0]         count_q, count_d;
  logic                               do_push, do_pop;

  assign full_o  = (int'(count_q) == ussc_pkg::QDepth);
  assign valid_o = (count_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (int'(wr_ptr_q) == ussc_pkg::QDepth - 1) ? '0 : wr_ptr_q + ussc_pkg::QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (int'(rd_ptr_q) == ussc_pkg::QDepth - 1) ? '0 : rd_ptr_q + ussc_pkg::QPtrW'(1);
    end
    if (do_push && !do_pop) count_d = count_q + ussc_pkg::QCntW'(1);
    if (!do_push && do_pop) count_d = count_q - ussc_pkg::QCntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= ussc_pkg::QDepth)
    else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== rtl/ussc_back.sv =====
`default_nettype none
module ussc_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ussc_pkg::cfg_t      cfg_i,
  input  wire logic                q_valid_i,
  input  wire ussc_pkg::seg_rec_t  rec_i,
  output logic                     pop_o,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output ussc_pkg::verdict_e       verdict_o,
  output logic [5:0]               ext_len_o
);

  ussc_pkg::cnt_t      whole;
  logic                has_ext;
  logic                whole_opaque;
  ussc_pkg::verdict_e  verdict_c;
  logic [5:0]          ext_c;
  logic                valid_q, valid_d;
  ussc_pkg::verdict_e  verdict_q;
  logic [5:0]          ext_q;

  assign whole = '{len: rec_i.whole_len, dig: rec_i.whole_dig, hex: rec_i.whole_hex,
                   flags: {2'b00, rec_i.whole_flags}};

  always_comb begin
    whole_opaque = ussc_pkg::opaque(whole, cfg_i);
    has_ext = rec_i.dot_seen && !rec_i.dot_first && (rec_i.comp_len != '0) &&
              (int'(rec_i.comp_len) <= int'(cfg_i.max_ext_len)) &&
              rec_i.comp_alnum && rec_i.comp_alpha;
    verdict_c = ussc_pkg::VerdictLiteral;
    ext_c     = '0;
    if (has_ext) begin
      if (rec_i.prev_opaque) begin
        verdict_c = ussc_pkg::VerdictStem;
        ext_c     = 6'(rec_i.comp_len);
      end
    end else if (whole_opaque) begin
      verdict_c = ussc_pkg::VerdictId;
    end
  end

  assign pop_o   = q_valid_i && (!valid_q || ready_i);
  assign valid_d = pop_o || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      verdict_q <= verdict_c;
      ext_q     <= ext_c;
    end
  end

  assign valid_o   = valid_q;
  assign verdict_o = verdict_q;
  assign ext_len_o = ext_q;

  a_ext_only_stem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (ext_q == '0) || (verdict_q == ussc_pkg::VerdictStem))
    else $error("extension length given without stem verdict");

  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q)
    else $error("popped record did not reach output register");

endmodule
`default_nettype wire
